// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define AST_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition implies an expression in the same cycle.
`define AST_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

`endif

// ===== rtl/lbph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbph_pkg
// Types, geometry constants and sample taps of the circular LBP histogram core.
// ----------------------------------------------------------------------------
package lbph_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MIN_SIZE    = 10;
   localparam int NEIGHBORS   = 8;
   localparam int LB_ROWS     = 3;
   localparam int HIST_DEPTH  = 16384;
   localparam int TAPS        = 4;

   localparam logic [14:0] COUNT_MAX = 15'd32767;
   localparam logic [16:0] FRAC_ONE  = 17'd65536;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;

   typedef struct packed {
      logic       kind;
      logic [7:0] pixel;
      logic       first_pixel;
      logic [5:0] cell_index;
      logic [7:0] bin_index;
   } req_type;

   typedef struct packed {
      logic        is_code;
      logic [7:0]  lbp_code;
      logic [9:0]  code_x;
      logic [9:0]  code_y;
      logic [14:0] bin_count;
      logic [16:0] bin_fraction;
   } rsp_type;

   // Bilinear taps on radius one: window row, window column and Q1.12 weight,
   // four taps per sample point, centre at row 1 column 1.
   localparam logic [1:0] TAP_ROW [NEIGHBORS*TAPS] = '{
      2'd1, 2'd1, 2'd1, 2'd1,
      2'd0, 2'd0, 2'd1, 2'd1,
      2'd0, 2'd0, 2'd0, 2'd0,
      2'd0, 2'd0, 2'd1, 2'd1,
      2'd1, 2'd1, 2'd1, 2'd1,
      2'd1, 2'd1, 2'd2, 2'd2,
      2'd2, 2'd2, 2'd2, 2'd2,
      2'd1, 2'd1, 2'd2, 2'd2
   };
   localparam logic [1:0] TAP_COL [NEIGHBORS*TAPS] = '{
      2'd2, 2'd2, 2'd2, 2'd2,
      2'd1, 2'd2, 2'd1, 2'd2,
      2'd1, 2'd1, 2'd1, 2'd1,
      2'd0, 2'd1, 2'd0, 2'd1,
      2'd0, 2'd0, 2'd0, 2'd0,
      2'd0, 2'd1, 2'd0, 2'd1,
      2'd1, 2'd1, 2'd1, 2'd1,
      2'd1, 2'd2, 2'd1, 2'd2
   };
   localparam logic [12:0] TAP_WEIGHT [NEIGHBORS*TAPS] = '{
      13'd4096, 13'd0,    13'd0,    13'd0,
      13'd848,  13'd2048, 13'd352,  13'd848,
      13'd4096, 13'd0,    13'd0,    13'd0,
      13'd2048, 13'd848,  13'd848,  13'd352,
      13'd4096, 13'd0,    13'd0,    13'd0,
      13'd848,  13'd352,  13'd2048, 13'd848,
      13'd4096, 13'd0,    13'd0,    13'd0,
      13'd352,  13'd848,  13'd848,  13'd2048
   };

endpackage

// ===== rtl/lbph_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbph_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lbph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/circular_lbp_grid_histogram_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// circular_lbp_grid_histogram_core
// Circular LBP codes on radius one with eight points, counted per grid cell.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A border pixel is accepted, then the line
// store read fills the window. A pixel that yields a code also passes the
// pattern code with the histogram read and then the histogram write back (plus
// any wait on the result side), as the histogram memory has one port per side.
// A bin read runs the bit-serial divider that forms the Q1.16 fraction (31
// quotient bits), skipped when the cell area is zero. The histogram memory of
// 16384 counts is cleared by a pass over every address after reset, and again
// when a first_pixel item arrives while counts are present; the input is held
// off during that pass, while configuration writes are taken as ever.
// ----------------------------------------------------------------------------
module circular_lbp_grid_histogram_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lbph_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lbph_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [10:0]         csr_data
);

   typedef enum logic [2:0] {
      S_SWEEP, S_IDLE, S_WIN, S_CODE, S_HWR, S_RD, S_DIV, S_ROUT
   } state_type;

   state_type          state_ff;
   logic [10:0]        width_ff, height_ff;
   logic [10:0]        col_ff, row_ff;
   logic [1:0]         phase_ff;
   logic [7:0]         pix_ff;
   logic [9:0]         cur_col_ff, cur_row_ff;
   logic [1:0]         cur_phase_ff;
   logic [7:0]         win_ff [3][3];
   logic [7:0]         code_ff;
   logic               counted_ff;
   logic [13:0]        haddr_ff;
   logic [13:0]        sweep_ff;
   logic               clean_ff;
   logic [14:0]        cnt_ff;
   logic [13:0]        total_ff;
   logic [13:0]        rem_ff;
   logic [30:0]        dvd_ff, quo_ff;
   logic [4:0]         step_ff;
   logic               rsp_valid_ff;
   lbph_pkg::rsp_type  rsp_ff;

   logic [10:0]        w_eff, h_eff;
   logic [6:0]         cw, ch;
   logic               req_fire, out_free, pix_fire, rd_fire, rsp_load;
   logic [10:0]        c0, r0, c1, col_in, row_in;
   logic [1:0]         p0, phase_in;
   logic               overrun;
   logic [7:0]         code_in;
   logic [9:0]         x_pos, y_pos;
   logic [2:0]         cx, cy;
   logic               counted_in;
   logic [7:0]         lb_rd [lbph_pkg::LB_ROWS];
   logic [14:0]        hist_rd;
   logic               hist_we, hist_re;
   logic [13:0]        hist_waddr, hist_raddr;
   logic [14:0]        hist_wdata;
   logic [14:0]        trial;

   // Next row phase, modulo the three line store banks.
   function automatic logic [1:0] phase_step(input logic [1:0] p);
      phase_step = (p == 2'd2) ? 2'd0 : p + 2'd1;
   endfunction

   // Cell coordinate of a position known to lie below eight cells.
   function automatic logic [2:0] cell_of(input logic [9:0] pos, input logic [6:0] size);
      logic [12:0] rem;
      logic [2:0]  q;
      rem = {3'd0, pos};
      q   = '0;
      if (rem >= {size, 2'b00}) begin q[2] = 1'b1; rem = rem - {4'd0, size, 2'b00}; end
      if (rem >= {size, 1'b0})  begin q[1] = 1'b1; rem = rem - {5'd0, size, 1'b0}; end
      if (rem >= {6'd0, size})  begin q[0] = 1'b1; end
      cell_of = q;
   endfunction

   // Clamp the size registers to the supported range.
   always_comb begin
      w_eff = width_ff;
      if (width_ff < 11'(lbph_pkg::MIN_SIZE)) w_eff = 11'(lbph_pkg::MIN_SIZE);
      if (width_ff > 11'(lbph_pkg::MAX_WIDTH)) w_eff = 11'(lbph_pkg::MAX_WIDTH);
      h_eff = height_ff;
      if (height_ff < 11'(lbph_pkg::MIN_SIZE)) h_eff = 11'(lbph_pkg::MIN_SIZE);
      if (height_ff > 11'(lbph_pkg::MAX_HEIGHT)) h_eff = 11'(lbph_pkg::MAX_HEIGHT);
   end

   // Cell size is the pattern image size over eight: a shift.
   assign cw = 7'((w_eff - 11'd2) >> 3);
   assign ch = 7'((h_eff - 11'd2) >> 3);

   // Hold off a frame start until the histograms are known clear.
   assign req_ready = (state_ff == S_IDLE) &&
                      !(req_valid && req_data.kind == lbph_pkg::KIND_PIXEL &&
                        req_data.first_pixel && !clean_ff);
   assign req_fire  = req_valid && req_ready;
   assign pix_fire  = req_fire && req_data.kind == lbph_pkg::KIND_PIXEL;
   assign rd_fire   = req_fire && req_data.kind == lbph_pkg::KIND_READ;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = out_free && (state_ff == S_HWR || state_ff == S_ROUT);
   assign csr_ready = 1'b1;

   // Position of the arriving pixel: restart on a frame start, wrap at width.
   always_comb begin
      c0 = req_data.first_pixel ? '0 : col_ff;
      r0 = req_data.first_pixel ? '0 : row_ff;
      p0 = req_data.first_pixel ? '0 : phase_ff;
      if (c0 >= w_eff) begin
         c0 = '0;
         r0 = r0 + 11'd1;
         p0 = phase_step(p0);
      end
      overrun  = r0 >= h_eff;
      c1       = c0 + 11'd1;
      col_in   = c1;
      row_in   = r0;
      phase_in = p0;
      if (c1 >= w_eff) begin
         col_in   = '0;
         row_in   = r0 + 11'd1;
         phase_in = phase_step(p0);
      end
      if (overrun) begin
         col_in   = c0;
         row_in   = h_eff;
         phase_in = p0;
      end
   end

   // Line store: one bank per row phase; write the new pixel, read the others.
   for (genvar b = 0; b < lbph_pkg::LB_ROWS; b++) begin : g_line
      lbph_ram #(
         .WIDTH (8),
         .DEPTH (lbph_pkg::MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (pix_fire && !overrun && p0 == 2'(b)),
         .wr_addr (c0[$clog2(lbph_pkg::MAX_WIDTH)-1:0]),
         .wr_data (req_data.pixel),
         .rd_en   (pix_fire),
         .rd_addr (c0[$clog2(lbph_pkg::MAX_WIDTH)-1:0]),
         .rd_data (lb_rd[b])
      );
   end

   // Pattern code from the registered window: eight weighted sums against centre.
   always_comb begin
      logic [19:0] sum;
      code_in = '0;
      for (int n = 0; n < lbph_pkg::NEIGHBORS; n++) begin
         sum = '0;
         for (int t = 0; t < lbph_pkg::TAPS; t++) begin
            sum = sum + 20'(lbph_pkg::TAP_WEIGHT[n*lbph_pkg::TAPS+t]) *
                  20'(win_ff[lbph_pkg::TAP_ROW[n*lbph_pkg::TAPS+t]]
                            [lbph_pkg::TAP_COL[n*lbph_pkg::TAPS+t]]);
         end
         code_in[n] = sum >= {win_ff[1][1], 12'd0};
      end
   end

   // Grid cell of the code; leftover edge pixels are not counted.
   assign x_pos      = cur_col_ff - 10'd2;
   assign y_pos      = cur_row_ff - 10'd2;
   assign counted_in = cw != '0 && ch != '0 &&
                       {3'd0, x_pos} < {cw, 3'd0} && {3'd0, y_pos} < {ch, 3'd0};
   assign cx = cell_of(x_pos, cw);
   assign cy = cell_of(y_pos, ch);

   // Histogram store: read on a bin read or a code, write on sweep or count.
   assign hist_re    = rd_fire || state_ff == S_CODE;
   assign hist_raddr = (state_ff == S_CODE) ? {cy, cx, code_in}
                                            : {req_data.cell_index, req_data.bin_index};
   assign hist_we    = state_ff == S_SWEEP ||
                       (state_ff == S_HWR && out_free && counted_ff);
   assign hist_waddr = (state_ff == S_SWEEP) ? sweep_ff : haddr_ff;
   assign hist_wdata = (state_ff == S_SWEEP) ? '0 :
                       (hist_rd == lbph_pkg::COUNT_MAX) ? hist_rd : hist_rd + 15'd1;

   lbph_ram #(
      .WIDTH (15),
      .DEPTH (lbph_pkg::HIST_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_en   (hist_re),
      .rd_addr (hist_raddr),
      .rd_data (hist_rd)
   );

   // One restoring division step.
   assign trial = {rem_ff, dvd_ff[30]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         clean_ff     <= 1'b0;
         width_ff     <= 11'(lbph_pkg::MAX_WIDTH);
         height_ff    <= 11'(lbph_pkg::MAX_HEIGHT);
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lbph_pkg::CSR_WIDTH:  width_ff  <= csr_data;
               lbph_pkg::CSR_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         // Load a new result, else drop the one just taken.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_SWEEP: begin
               sweep_ff <= sweep_ff + 14'd1;
               if (sweep_ff == 14'(lbph_pkg::HIST_DEPTH - 1)) begin
                  clean_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid && req_data.kind == lbph_pkg::KIND_PIXEL &&
                   req_data.first_pixel && !clean_ff) begin
                  sweep_ff <= '0;
                  state_ff <= S_SWEEP;
               end else if (pix_fire) begin
                  col_ff       <= col_in;
                  row_ff       <= row_in;
                  phase_ff     <= phase_in;
                  pix_ff       <= req_data.pixel;
                  cur_col_ff   <= c0[9:0];
                  cur_row_ff   <= r0[9:0];
                  cur_phase_ff <= p0;
                  if (!overrun) state_ff <= S_WIN;
               end else if (rd_fire) begin
                  state_ff <= S_RD;
               end
            end
            S_WIN: begin
               // Advance the window one column: two stored rows and the new pixel.
               for (int r = 0; r < 3; r++) begin
                  win_ff[r][0] <= win_ff[r][1];
                  win_ff[r][1] <= win_ff[r][2];
               end
               win_ff[0][2] <= lb_rd[phase_step(cur_phase_ff)];
               win_ff[1][2] <= lb_rd[phase_step(phase_step(cur_phase_ff))];
               win_ff[2][2] <= pix_ff;
               state_ff <= (cur_row_ff >= 10'd2 && cur_col_ff >= 10'd2) ? S_CODE : S_IDLE;
            end
            S_CODE: begin
               code_ff    <= code_in;
               counted_ff <= counted_in;
               haddr_ff   <= {cy, cx, code_in};
               state_ff   <= S_HWR;
            end
            S_HWR: begin
               if (out_free) begin
                  rsp_ff.is_code       <= 1'b1;
                  rsp_ff.lbp_code      <= code_ff;
                  rsp_ff.code_x        <= x_pos;
                  rsp_ff.code_y        <= y_pos;
                  rsp_ff.bin_count     <= '0;
                  rsp_ff.bin_fraction  <= '0;
                  if (counted_ff) clean_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            S_RD: begin
               cnt_ff   <= hist_rd;
               dvd_ff   <= {hist_rd, 16'd0};
               total_ff <= {7'd0, cw} * {7'd0, ch};
               rem_ff   <= '0;
               quo_ff   <= '0;
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (total_ff == '0) begin
                  state_ff <= S_ROUT;
               end else begin
                  dvd_ff <= {dvd_ff[29:0], 1'b0};
                  if (trial >= {1'b0, total_ff}) begin
                     rem_ff <= 14'(trial - {1'b0, total_ff});
                     quo_ff <= {quo_ff[29:0], 1'b1};
                  end else begin
                     rem_ff <= trial[13:0];
                     quo_ff <= {quo_ff[29:0], 1'b0};
                  end
                  step_ff <= step_ff + 5'd1;
                  if (step_ff == 5'd30) state_ff <= S_ROUT;
               end
            end
            S_ROUT: begin
               if (out_free) begin
                  rsp_ff.is_code      <= 1'b0;
                  rsp_ff.lbp_code     <= '0;
                  rsp_ff.code_x       <= '0;
                  rsp_ff.code_y       <= '0;
                  rsp_ff.bin_count    <= cnt_ff;
                  // Saturate a fraction above one, possible after a resize.
                  rsp_ff.bin_fraction <= (quo_ff > {14'd0, lbph_pkg::FRAC_ONE}) ?
                                         lbph_pkg::FRAC_ONE : quo_ff[16:0];
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `AST_ALWAYS(a_frame_starts_clean, !(pix_fire && req_data.first_pixel && !clean_ff), "frame accepted with stale histograms")
   `AST_IMPLY(a_code_has_no_count, rsp_valid_ff && rsp_ff.is_code, rsp_ff.bin_count == '0 && rsp_ff.bin_fraction == '0, "code result carries count fields")
   `AST_IMPLY(a_fraction_saturated, rsp_valid_ff, rsp_ff.bin_fraction <= lbph_pkg::FRAC_ONE, "fraction above one")
   `AST_IMPLY(a_sweep_holds_input, state_ff == S_SWEEP, !req_ready, "item accepted during clearing pass")

endmodule
